@@ src/set_assoc_cache_lookup_replace_defines.svh @@
// Assertion macros shared by the cache tag store checkers.
`ifndef SET_ASSOC_CACHE_LOOKUP_REPLACE_DEFINES_SVH
`define SET_ASSOC_CACHE_LOOKUP_REPLACE_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define SACL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sacl_pkg.sv @@
// Shared constants for the set-associative cache tag store.
`timescale 1ns / 1ps

package sacl_pkg;

   // fixed port field widths
   localparam int SET_IDX_W = 6;
   localparam int TAG_W     = 20;
   localparam int WAY_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CNT_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_HIT     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FILL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REPLACE = 2'd2;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_POLICY   = 1'b1;

   // policy encodings
   localparam logic REPLACE_LRU    = 1'b0;
   localparam logic REPLACE_FIFO   = 1'b1;
   localparam logic WRITE_THRU     = 1'b0;
   localparam logic WRITE_COPYBACK = 1'b1;

   // access kinds
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

endpackage

@@ src/set_assoc_cache_lookup_replace.sv @@
// Set-associative cache tag store: lookup, fill, LRU/FIFO replacement, hit/miss counters.
//
//   channel   ports                         handshake
//   request   req_set_index, req_tag,       start & !busy
//             req_mode
//   response  rsp_status, rsp_way,          rsp_strobe, one cycle, no back-pressure
//             rsp_evict_*, rsp_write_down,
//             rsp_hit_total, rsp_miss_total
//   control   csr_index, csr_data           csr_write, no wait
//
// One word accepted per clock. The accepting edge latches the word and reads the set's row
// from the row memory (registered read port); the next cycle compares all ways in parallel,
// and its closing edge writes the row back and registers the response, raising rsp_strobe.
// The row written in the previous cycle is forwarded when the same set follows directly.
// Reset is synchronous: valid bits, counters and policies clear at once; busy is
// high only while reset is high. Nothing downstream can stall the block.
`timescale 1ns / 1ps

module set_assoc_cache_lookup_replace
   import sacl_pkg::*;
#(
   parameter int SETS        = 64,
   parameter int WAYS        = 4,
   parameter int TAG_STORE_W = 20,
   parameter int AGE_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [SET_IDX_W-1:0] req_set_index,
   input  logic [TAG_W-1:0]     req_tag,
   input  logic                 req_mode,
   output logic                 rsp_strobe,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [WAY_W-1:0]     rsp_way,
   output logic                 rsp_evict_dirty,
   output logic [TAG_W-1:0]     rsp_evict_tag,
   output logic                 rsp_write_down,
   output logic [CNT_W-1:0]     rsp_hit_total,
   output logic [CNT_W-1:0]     rsp_miss_total,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int SET_AW      = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_ENTRIES = 2 ** SET_IDX_W;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
   localparam logic [CNT_W-1:0]    CNT_MAX = '1;

   typedef struct packed {
      logic                   dirty;
      logic [AGE_BITS-1:0]    age;
      logic [TAG_STORE_W-1:0] tag;
   } line_type;

   typedef line_type [WAYS-1:0] row_type;

   // set index wrap table, constant per entry
   logic [SET_AW-1:0] set_tbl [SET_ENTRIES];

   for (genvar g = 0; g < SET_ENTRIES; g++) begin : g_wrap
      assign set_tbl[g] = SET_AW'(g % SETS);
   end

   logic                 accept;
   logic [SET_AW-1:0]    req_set;

   // stage one
   logic                   s1_valid_ff;
   logic [SET_AW-1:0]      s1_set_ff;
   logic [TAG_STORE_W-1:0] s1_tag_ff;
   logic                   s1_mode_ff;
   row_type                rd_row_ff;
   row_type                row_mem_ff [SETS];

   // last written row, for forwarding
   logic                 wb_valid_ff;
   logic [SET_AW-1:0]    wb_set_ff;
   row_type              wb_row_ff;

   logic [SETS-1:0][WAYS-1:0] valid_ff;

   logic                 replace_policy_ff;
   logic                 write_policy_ff;

   logic [CNT_W-1:0]     hit_cnt_ff;
   logic [CNT_W-1:0]     miss_cnt_ff;

   // response registers
   logic                 rsp_strobe_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [WAY_W-1:0]     way_ff;
   logic                 evict_dirty_ff;
   logic [TAG_W-1:0]     evict_tag_ff;
   logic                 write_down_ff;

   // stage two logic
   row_type              cur_row;
   logic [WAYS-1:0]      cur_valid;
   logic [WAYS-1:0]      hit_vec;
   logic [WAYS-1:0]      free_vec;
   logic [WAYS-1:0]      victim_vec;
   logic [AGE_BITS-1:0]  aged [WAYS];
   logic                 any_hit;
   logic                 any_free;
   logic [WAY_BITS-1:0]  hit_way;
   logic [WAY_BITS-1:0]  free_way;
   logic [WAY_BITS-1:0]  victim_way;
   logic [WAY_BITS-1:0]  sel_way;
   logic [STATUS_W-1:0]  status_in;
   logic                 evict_dirty_in;
   logic [TAG_W-1:0]     evict_tag_in;
   logic                 wr_back;
   row_type              new_row;
   logic [WAYS-1:0]      new_valid;

   assign busy    = reset;
   assign accept  = start && !busy;
   assign req_set = set_tbl[req_set_index];

   // row memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         row_mem_ff[s1_set_ff] <= new_row;
      end
      rd_row_ff <= row_mem_ff[req_set];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_set_ff  <= req_set;
      s1_tag_ff  <= TAG_STORE_W'(req_tag);
      s1_mode_ff <= req_mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         wb_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            valid_ff[s1_set_ff] <= new_valid;
         end
      end
      wb_set_ff <= s1_set_ff;
      wb_row_ff <= new_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replace_policy_ff <= REPLACE_LRU;
         write_policy_ff   <= WRITE_COPYBACK;
      end else if (csr_write) begin
         case (csr_index)
            CSR_REPLACE_POLICY: replace_policy_ff <= csr_data[0];
            CSR_WRITE_POLICY:   write_policy_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_row   = (wb_valid_ff && (wb_set_ff == s1_set_ff)) ? wb_row_ff : rd_row_ff;
      cur_valid = valid_ff[s1_set_ff];
      wr_back   = (write_policy_ff == WRITE_COPYBACK) && (s1_mode_ff == MODE_WRITE);

      // invalid ways read as cleared entries
      for (int i = 0; i < WAYS; i++) begin
         if (!cur_valid[i]) begin
            cur_row[i] = '0;
         end
      end

      for (int i = 0; i < WAYS; i++) begin
         hit_vec[i]  = cur_valid[i] && (cur_row[i].tag == s1_tag_ff);
         free_vec[i] = !cur_valid[i];
         aged[i]     = (cur_valid[i] && (cur_row[i].age != AGE_MAX)) ?
                       cur_row[i].age + AGE_BITS'(1) : cur_row[i].age;
      end

      // lowest way holding the greatest age: strictly above lower ways, not below higher
      for (int i = 0; i < WAYS; i++) begin
         victim_vec[i] = 1'b1;
         for (int j = 0; j < WAYS; j++) begin
            if (j < i) begin
               victim_vec[i] = victim_vec[i] && (aged[i] > aged[j]);
            end else if (j > i) begin
               victim_vec[i] = victim_vec[i] && (aged[i] >= aged[j]);
            end
         end
      end

      any_hit    = |hit_vec;
      any_free   = |free_vec;
      hit_way    = '0;
      free_way   = '0;
      victim_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_way = WAY_BITS'(i);
         end
         if (free_vec[i]) begin
            free_way = WAY_BITS'(i);
         end
         if (victim_vec[i]) begin
            victim_way = WAY_BITS'(i);
         end
      end

      evict_dirty_in = 1'b0;
      evict_tag_in   = '0;
      if (any_hit) begin
         status_in = STATUS_HIT;
         sel_way   = hit_way;
      end else if (any_free) begin
         status_in = STATUS_FILL;
         sel_way   = free_way;
      end else begin
         status_in      = STATUS_REPLACE;
         sel_way        = victim_way;
         evict_dirty_in = cur_row[victim_way].dirty;
         evict_tag_in   = TAG_W'(cur_row[victim_way].tag);
      end

      new_row = cur_row;
      for (int i = 0; i < WAYS; i++) begin
         new_row[i].age = aged[i];
      end
      new_valid = cur_valid;
      if (any_hit) begin
         if (replace_policy_ff == REPLACE_LRU) begin
            new_row[sel_way].age = '0;
         end
         if (wr_back) begin
            new_row[sel_way].dirty = 1'b1;
         end
      end else begin
         new_row[sel_way].tag   = s1_tag_ff;
         new_row[sel_way].dirty = wr_back;
         new_row[sel_way].age   = '0;
         new_valid[sel_way]     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            if (any_hit) begin
               if (hit_cnt_ff != CNT_MAX) begin
                  hit_cnt_ff <= hit_cnt_ff + CNT_W'(1);
               end
            end else if (miss_cnt_ff != CNT_MAX) begin
               miss_cnt_ff <= miss_cnt_ff + CNT_W'(1);
            end
         end
      end
      status_ff      <= status_in;
      way_ff         <= WAY_W'(sel_way);
      evict_dirty_ff <= evict_dirty_in;
      evict_tag_ff   <= evict_tag_in;
      write_down_ff  <= (write_policy_ff == WRITE_THRU) && (s1_mode_ff == MODE_WRITE);
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_way         = way_ff;
   assign rsp_evict_dirty = evict_dirty_ff;
   assign rsp_evict_tag   = evict_tag_ff;
   assign rsp_write_down  = write_down_ff;
   assign rsp_hit_total   = hit_cnt_ff;
   assign rsp_miss_total  = miss_cnt_ff;

endmodule

@@ src/sacl_checker.sv @@
// Port-level checker for the cache tag store, bound to the top level.
`timescale 1ns / 1ps
`include "set_assoc_cache_lookup_replace_defines.svh"

module sacl_checker
   import sacl_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_evict_dirty,
   input logic [TAG_W-1:0]    rsp_evict_tag,
   input logic [CNT_W-1:0]    rsp_hit_total,
   input logic [CNT_W-1:0]    rsp_miss_total
);

   // every accepted word gets a response strobe
   `SACL_ASSERT_NEXT(a_latency, start && !busy, ##1 rsp_strobe, "accepted word gave no response")

   // only a replacement reports a victim
   `SACL_ASSERT_SAME(a_no_victim, rsp_strobe && (rsp_status != STATUS_REPLACE), (!rsp_evict_dirty && (rsp_evict_tag == '0)), "victim fields set without replacement")

   // a hit bumps the hit count only
   `SACL_ASSERT_SAME(a_hit_count, rsp_strobe && (rsp_status == STATUS_HIT), ((rsp_hit_total == $past(rsp_hit_total) + 32'd1) || (rsp_hit_total == '1)) && $stable(rsp_miss_total), "hit count not advanced")

   // counters move only with a response
   `SACL_ASSERT_SAME(a_count_hold, !rsp_strobe && !$past(reset), $stable(rsp_hit_total) && $stable(rsp_miss_total), "counters changed without a response")

endmodule

bind set_assoc_cache_lookup_replace sacl_checker u_sacl_checker (.*);

@@ sim/testbench.sv @@
// Testbench for the cache tag store: directed table, then random policy phases.
`timescale 1ns / 1ps

module testbench;
   import sacl_pkg::*;

   localparam int WAYS        = 4;
   localparam int LINES       = 64 * WAYS;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_WORDS = 255;
   localparam int NUM_ROWS    = 23;
   localparam logic [15:0] AGE_MAX = 16'hFFFF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WAY_W-1:0]    way;
      logic                evict_dirty;
      logic [TAG_W-1:0]    evict_tag;
      logic                write_down;
      logic [CNT_W-1:0]    hit_total;
      logic [CNT_W-1:0]    miss_total;
   } lookup_rsp_type;

   typedef enum logic {ROW_ACCESS, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [CSR_DAT_W-1:0]   reg_val;
      logic [SET_IDX_W-1:0]   set_idx;
      logic [TAG_W-1:0]       tag;
      logic                   mode;
      logic                   typed;
      lookup_rsp_type         rsp;
   } dir_row_type;

   localparam lookup_rsp_type NO_RSP = '0;

   // typed rows: reset state, fill order, first victim (dirty, tag zero), last set
   localparam dir_row_type DIR_ROWS [NUM_ROWS] = '{
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h00000, MODE_READ, 1'b1,
        '{STATUS_FILL, 2'd0, 1'b0, 20'h0, 1'b0, 32'd0, 32'd1}},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h00000, MODE_WRITE, 1'b1,
        '{STATUS_HIT, 2'd0, 1'b0, 20'h0, 1'b0, 32'd1, 32'd1}},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'hFFFFF, MODE_READ, 1'b1,
        '{STATUS_FILL, 2'd1, 1'b0, 20'h0, 1'b0, 32'd1, 32'd2}},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h00001, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h00002, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h00003, MODE_READ, 1'b1,
        '{STATUS_REPLACE, 2'd0, 1'b1, 20'h0, 1'b0, 32'd1, 32'd5}},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd63, 20'hFFFFF, MODE_WRITE, 1'b1,
        '{STATUS_FILL, 2'd0, 1'b0, 20'h0, 1'b0, 32'd1, 32'd6}},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'hFFFFF, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_CSR, CSR_WRITE_POLICY, WRITE_THRU, 6'd0, 20'h0, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h00003, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'hABCDE, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd1, 20'h00005, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_CSR, CSR_REPLACE_POLICY, REPLACE_FIFO, 6'd0, 20'h0, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h00003, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h12345, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h54321, MODE_READ, 1'b0, NO_RSP},
      '{ROW_CSR, CSR_WRITE_POLICY, WRITE_COPYBACK, 6'd0, 20'h0, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'h55555, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd0, 20'hAAAAA, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd42, 20'h0F0F0, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd42, 20'h0F0F0, MODE_WRITE, 1'b0, NO_RSP},
      '{ROW_CSR, CSR_REPLACE_POLICY, REPLACE_LRU, 6'd0, 20'h0, MODE_READ, 1'b0, NO_RSP},
      '{ROW_ACCESS, CSR_REPLACE_POLICY, 1'b0, 6'd63, 20'hFFFFF, MODE_READ, 1'b0, NO_RSP}
   };

   localparam logic PH_REPLACE [RAND_PHASES] = '{REPLACE_LRU, REPLACE_FIFO, REPLACE_LRU,
                                                 REPLACE_FIFO, REPLACE_FIFO, REPLACE_LRU};
   localparam logic PH_WRITE [RAND_PHASES]   = '{WRITE_COPYBACK, WRITE_THRU, WRITE_THRU,
                                                 WRITE_COPYBACK, WRITE_THRU, WRITE_COPYBACK};
   localparam int PH_IDLE [RAND_PHASES]      = '{0, 55, 14, 0, 55, 14};

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [SET_IDX_W-1:0] req_set_index;
   logic [TAG_W-1:0]     req_tag;
   logic                 req_mode;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [WAY_W-1:0]     rsp_way;
   logic                 rsp_evict_dirty;
   logic [TAG_W-1:0]     rsp_evict_tag;
   logic                 rsp_write_down;
   logic [CNT_W-1:0]     rsp_hit_total;
   logic [CNT_W-1:0]     rsp_miss_total;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   set_assoc_cache_lookup_replace u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_set_index   (req_set_index),
      .req_tag         (req_tag),
      .req_mode        (req_mode),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_way         (rsp_way),
      .rsp_evict_dirty (rsp_evict_dirty),
      .rsp_evict_tag   (rsp_evict_tag),
      .rsp_write_down  (rsp_write_down),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // shadow copy of the tag store
   logic [TAG_W-1:0] shadow_tag   [LINES];
   logic             shadow_valid [LINES];
   logic             shadow_dirty [LINES];
   logic [15:0]      shadow_age   [LINES];
   logic [CNT_W-1:0] shadow_hits;
   logic [CNT_W-1:0] shadow_misses;
   logic             cur_replace;
   logic             cur_write;

   lookup_rsp_type pending_rsp [$];

   int errors;
   int n_words;
   int n_hit;
   int n_fill;
   int n_replace;
   int n_dirty_ev;
   int n_wdown;

   function automatic void clear_shadow();
      foreach (shadow_tag[k]) begin
         shadow_tag[k]   = '0;
         shadow_valid[k] = 1'b0;
         shadow_dirty[k] = 1'b0;
         shadow_age[k]   = '0;
      end
      shadow_hits   = '0;
      shadow_misses = '0;
      cur_replace   = REPLACE_LRU;
      cur_write     = WRITE_COPYBACK;
   endfunction

   function automatic lookup_rsp_type predict_lookup(input logic [SET_IDX_W-1:0] set_idx,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic mode);
      int             base;
      int             hit_way;
      int             free_way;
      int             victim;
      int             k;
      logic [15:0]    oldest;
      logic           mark_dirty;
      lookup_rsp_type r;
      base       = int'(set_idx) * WAYS;
      hit_way    = -1;
      free_way   = -1;
      r          = '0;
      mark_dirty = (cur_write == WRITE_COPYBACK) && (mode == MODE_WRITE);
      for (int i = 0; i < WAYS; i++) begin
         if (shadow_valid[base+i]) begin
            if (hit_way < 0 && shadow_tag[base+i] == tag) hit_way = i;
         end else if (free_way < 0) begin
            free_way = i;
         end
      end
      for (int i = 0; i < WAYS; i++)
         if (shadow_valid[base+i] && shadow_age[base+i] != AGE_MAX)
            shadow_age[base+i] = shadow_age[base+i] + 16'd1;
      if (hit_way >= 0) begin
         k        = base + hit_way;
         r.status = STATUS_HIT;
         r.way    = WAY_W'(hit_way);
         if (shadow_hits != '1) shadow_hits = shadow_hits + 1;
         if (cur_replace == REPLACE_LRU) shadow_age[k] = '0;
         if (mark_dirty) shadow_dirty[k] = 1'b1;
      end else begin
         if (shadow_misses != '1) shadow_misses = shadow_misses + 1;
         if (free_way >= 0) begin
            r.status = STATUS_FILL;
            victim   = free_way;
         end else begin
            // lowest way among those holding the greatest age
            r.status = STATUS_REPLACE;
            victim   = 0;
            oldest   = '0;
            for (int i = 0; i < WAYS; i++)
               if (shadow_age[base+i] > oldest) begin
                  oldest = shadow_age[base+i];
                  victim = i;
               end
            r.evict_dirty = shadow_dirty[base+victim];
            r.evict_tag   = shadow_tag[base+victim];
         end
         k               = base + victim;
         r.way           = WAY_W'(victim);
         shadow_tag[k]   = tag;
         shadow_valid[k] = 1'b1;
         shadow_dirty[k] = mark_dirty;
         shadow_age[k]   = '0;
      end
      r.write_down = (cur_write == WRITE_THRU) && (mode == MODE_WRITE);
      r.hit_total  = shadow_hits;
      r.miss_total = shadow_misses;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      lookup_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: response word with none pending, status %0d way %0d",
                     $time, rsp_status, rsp_way);
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("way", want.way, rsp_way);
            check_field("evict_dirty", want.evict_dirty, rsp_evict_dirty);
            check_field("evict_tag", want.evict_tag, rsp_evict_tag);
            check_field("write_down", want.write_down, rsp_write_down);
            check_field("hit_total", want.hit_total, rsp_hit_total);
            check_field("miss_total", want.miss_total, rsp_miss_total);
            case (want.status)
               STATUS_HIT:     n_hit++;
               STATUS_FILL:    n_fill++;
               STATUS_REPLACE: n_replace++;
               default: ;
            endcase
            if (want.evict_dirty) n_dirty_ev++;
            if (want.write_down) n_wdown++;
         end
      end
   end

   task automatic send_access(input logic [SET_IDX_W-1:0] set_idx, input logic [TAG_W-1:0] tag,
                              input logic mode, input logic use_typed,
                              input lookup_rsp_type typed_rsp);
      lookup_rsp_type predicted;
      @(negedge clock);
      start         <= 1'b1;
      req_set_index <= set_idx;
      req_tag       <= tag;
      req_mode      <= mode;
      do @(posedge clock); while (busy);
      predicted = predict_lookup(set_idx, tag, mode);
      pending_rsp.push_back(use_typed ? typed_rsp : predicted);
      n_words++;
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain();
      hold_off(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_REPLACE_POLICY) cur_replace = val;
      else cur_write = val;
   endtask

   initial begin : stimulus
      logic [SET_IDX_W-1:0] hot_set  [4];
      logic [TAG_W-1:0]     tag_pool [6];
      logic [SET_IDX_W-1:0] s;
      logic [TAG_W-1:0]     t;
      reset         = 1'b1;
      start         = 1'b0;
      req_set_index = '0;
      req_tag       = '0;
      req_mode      = MODE_READ;
      csr_write     = 1'b0;
      csr_index     = CSR_REPLACE_POLICY;
      csr_data      = '0;
      errors        = 0;
      n_words       = 0;
      n_hit         = 0;
      n_fill        = 0;
      n_replace     = 0;
      n_dirty_ev    = 0;
      n_wdown       = 0;
      clear_shadow();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].kind == ROW_CSR)
            write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].reg_val);
         else
            send_access(DIR_ROWS[i].set_idx, DIR_ROWS[i].tag, DIR_ROWS[i].mode,
                        DIR_ROWS[i].typed, DIR_ROWS[i].rsp);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         write_reg(CSR_REPLACE_POLICY, PH_REPLACE[ph]);
         write_reg(CSR_WRITE_POLICY, PH_WRITE[ph]);
         foreach (hot_set[k]) hot_set[k] = SET_IDX_W'($urandom_range(0, 63));
         foreach (tag_pool[k]) tag_pool[k] = TAG_W'($urandom_range(0, 20'hFFFFF));
         repeat (PHASE_WORDS) begin
            if ($urandom_range(0, 99) < PH_IDLE[ph]) hold_off(int'($urandom_range(1, 3)));
            // mostly a few busy sets and a small tag pool, so hits and evictions are common
            if ($urandom_range(0, 99) < 70) s = hot_set[$urandom_range(0, 3)];
            else s = SET_IDX_W'($urandom_range(0, 63));
            if ($urandom_range(0, 99) < 85) t = tag_pool[$urandom_range(0, 5)];
            else t = TAG_W'($urandom_range(0, 20'hFFFFF));
            send_access(s, t, 1'($urandom_range(0, 1)), 1'b0, NO_RSP);
         end
      end

      drain();
      $display("Run covered %0d lookups: %0d hits, %0d fills, %0d replacements",
               n_words, n_hit, n_fill, n_replace);
      $display("LRU/FIFO with write-back/write-through, %0d dirty evictions, %0d writes passed down",
               n_dirty_ev, n_wdown);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
